@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the infrared transmitter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

@@ design/ipdt_pkg.sv @@
// ----------------------------------------------------------------------------
// ipdt_pkg
// Types and constants shared by the infrared pulse distance transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ipdt_pkg;

   // Number of command bits sent per frame
   localparam int CODE_BITS = 32;

   // Operation codes on the request channel
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Control register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAD_MARK      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAD_SPACE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_MARK       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_SPACE      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_SPACE     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_SPACE     = 3'd7;

   // Control register file contents
   typedef struct packed {
      logic [7:0]  carrier_period;
      logic [7:0]  carrier_high;
      logic [15:0] lead_mark_ticks;
      logic [15:0] lead_space_ticks;
      logic [15:0] bit_mark_ticks;
      logic [15:0] one_space_ticks;
      logic [15:0] zero_space_ticks;
      logic [15:0] stop_space_ticks;
   } cfg_type;

   // Status for one processed item
   typedef struct packed {
      logic line_level;
      logic mark_active;
      logic busy_res;
      logic frame_done;
      logic start_rejected;
   } result_type;

endpackage

`default_nettype wire

@@ design/ipdt_csr.sv @@
// ----------------------------------------------------------------------------
// ipdt_csr
// Control register file: timing and carrier settings, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module ipdt_csr
   import ipdt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CARRIER_PERIOD: cfg_in.carrier_period   = csr_write_data[7:0];
            CSR_CARRIER_HIGH:   cfg_in.carrier_high     = csr_write_data[7:0];
            CSR_LEAD_MARK:      cfg_in.lead_mark_ticks  = csr_write_data;
            CSR_LEAD_SPACE:     cfg_in.lead_space_ticks = csr_write_data;
            CSR_BIT_MARK:       cfg_in.bit_mark_ticks   = csr_write_data;
            CSR_ONE_SPACE:      cfg_in.one_space_ticks  = csr_write_data;
            CSR_ZERO_SPACE:     cfg_in.zero_space_ticks = csr_write_data;
            CSR_STOP_SPACE:     cfg_in.stop_space_ticks = csr_write_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.carrier_period   <= 8'd25;
         cfg_ff.carrier_high     <= 8'd12;
         cfg_ff.lead_mark_ticks  <= 16'd9000;
         cfg_ff.lead_space_ticks <= 16'd4500;
         cfg_ff.bit_mark_ticks   <= 16'd560;
         cfg_ff.one_space_ticks  <= 16'd1690;
         cfg_ff.zero_space_ticks <= 16'd560;
         cfg_ff.stop_space_ticks <= 16'd1690;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ design/ipdt_engine.sv @@
// ----------------------------------------------------------------------------
// ipdt_engine
// Frame sequencer: phase, tick and carrier counters, command shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module ipdt_engine
   import ipdt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  wire logic                 item_op,
   input  wire logic [CODE_BITS-1:0] item_command,
   input  wire cfg_type              cfg,
   output result_type                result
);

   `include "assert_macros.svh"

   localparam int BITS_W = $clog2(CODE_BITS + 1);
   localparam logic [BITS_W-1:0] BITS_FULL = BITS_W'(CODE_BITS);

   // Frame phase codes
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_LEAD_MARK  = 3'd1;
   localparam logic [2:0] PH_LEAD_SPACE = 3'd2;
   localparam logic [2:0] PH_BIT_MARK   = 3'd3;
   localparam logic [2:0] PH_BIT_SPACE  = 3'd4;
   localparam logic [2:0] PH_STOP_MARK  = 3'd5;
   localparam logic [2:0] PH_STOP_SPACE = 3'd6;

   function automatic logic is_mark(input logic [2:0] ph);
      return (ph == PH_LEAD_MARK) || (ph == PH_BIT_MARK) || (ph == PH_STOP_MARK);
   endfunction

   logic [2:0]           phase_ff,    phase_in;
   logic [15:0]          tick_cnt_ff, tick_cnt_in;
   logic [7:0]           carrier_ff,  carrier_in;
   logic [BITS_W-1:0]    bits_ff,     bits_in;
   logic [CODE_BITS-1:0] code_ff,     code_in;

   logic [15:0]       phase_len;
   logic [15:0]       tick_inc;
   logic [7:0]        carrier_step;
   logic [BITS_W-1:0] bits_dec;
   logic              done;
   logic              rejected;

   // Length of the current phase
   always_comb begin
      case (phase_ff)
         PH_LEAD_MARK:  phase_len = cfg.lead_mark_ticks;
         PH_LEAD_SPACE: phase_len = cfg.lead_space_ticks;
         PH_BIT_MARK:   phase_len = cfg.bit_mark_ticks;
         PH_BIT_SPACE:  phase_len = code_ff[CODE_BITS-1] ? cfg.one_space_ticks
                                                         : cfg.zero_space_ticks;
         PH_STOP_MARK:  phase_len = cfg.bit_mark_ticks;
         PH_STOP_SPACE: phase_len = cfg.stop_space_ticks;
         default:       phase_len = 16'd1;
      endcase
   end

   assign tick_inc     = tick_cnt_ff + 16'd1;
   assign bits_dec     = bits_ff - BITS_W'(1);
   assign carrier_step = (carrier_ff >= cfg.carrier_period) ? 8'd0 : carrier_ff + 8'd1;

   // Next state for one accepted item
   always_comb begin
      phase_in    = phase_ff;
      tick_cnt_in = tick_cnt_ff;
      carrier_in  = carrier_ff;
      bits_in     = bits_ff;
      code_in     = code_ff;
      done        = 1'b0;
      rejected    = 1'b0;
      if (item_op == OP_START) begin
         if (phase_ff != PH_IDLE) begin
            rejected = 1'b1;
         end else begin
            code_in     = item_command;
            bits_in     = BITS_FULL;
            phase_in    = PH_LEAD_MARK;
            tick_cnt_in = 16'd0;
            carrier_in  = 8'd0;
         end
      end else if (phase_ff != PH_IDLE) begin
         if (is_mark(phase_ff)) begin
            carrier_in = carrier_step;
         end
         if ((tick_inc < phase_len) && (tick_inc != 16'd0)) begin
            tick_cnt_in = tick_inc;
         end else begin
            tick_cnt_in = 16'd0;
            case (phase_ff)
               PH_LEAD_MARK:  phase_in = PH_LEAD_SPACE;
               PH_LEAD_SPACE: phase_in = PH_BIT_MARK;
               PH_BIT_MARK:   phase_in = PH_BIT_SPACE;
               PH_BIT_SPACE: begin
                  code_in  = {code_ff[CODE_BITS-2:0], 1'b0};
                  bits_in  = bits_dec;
                  phase_in = (bits_dec == '0) ? PH_STOP_MARK : PH_BIT_MARK;
               end
               PH_STOP_MARK:  phase_in = PH_STOP_SPACE;
               PH_STOP_SPACE: begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
               default:       phase_in = PH_IDLE;
            endcase
            // Carrier restarts with every mark
            if (is_mark(phase_in)) begin
               carrier_in = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_cnt_ff <= 16'd0;
         carrier_ff  <= 8'd0;
         bits_ff     <= '0;
         code_ff     <= '0;
      end else if (item_valid) begin
         phase_ff    <= phase_in;
         tick_cnt_ff <= tick_cnt_in;
         carrier_ff  <= carrier_in;
         bits_ff     <= bits_in;
         code_ff     <= code_in;
      end
   end

   // Status after this item
   always_comb begin
      result.mark_active    = is_mark(phase_in);
      result.line_level     = is_mark(phase_in) && (carrier_in < cfg.carrier_high);
      result.busy_res       = (phase_in != PH_IDLE);
      result.frame_done     = done;
      result.start_rejected = rejected;
   end

   `ASSERT_ALWAYS(a_bits_range, clock, reset, bits_ff <= BITS_FULL)
   `ASSERT_IMPLY(a_idle_count_clear, clock, reset, phase_ff == PH_IDLE, tick_cnt_ff == 16'd0)
   `ASSERT_IMPLY(a_bit_phase_has_bits, clock, reset,
      (phase_ff == PH_BIT_MARK) || (phase_ff == PH_BIT_SPACE), bits_ff != '0)

endmodule

`default_nettype wire

@@ design/infrared_pulse_distance_transmitter.sv @@
// ----------------------------------------------------------------------------
// infrared_pulse_distance_transmitter
// Pulse-distance infrared frame transmitter with carrier modulation.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall): req_op selects a one microsecond
//   tick or a frame start; req_command carries the 32-bit code for a start.
//   Response channel (rsp_valid/rsp_stall): exactly one transfer per request,
//   in order, with the line level and frame status after that request.
//   Control port (csr_*): plain writes of the timing and carrier registers,
//   done while no request is outstanding.
//   A response is presented in the cycle after its request transfer.
//   Throughput: one request per cycle when not stalled; frame state updates
//   in the cycle of the transfer, status lands in a single output register.
//   Stall: while a held response is stalled, req_stall is raised; once the
//   response drains, a new request is taken in the same cycle.
//   Reset: synchronous, clears the frame to idle, empties the output register
//   and restores register defaults (38 kHz-style carrier, standard timings).
// ----------------------------------------------------------------------------
`default_nettype none

module infrared_pulse_distance_transmitter
   import ipdt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_op,
   input  wire logic [31:0]            req_command,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_line_level,
   output logic                        rsp_mark_active,
   output logic                        rsp_busy_res,
   output logic                        rsp_frame_done,
   output logic                        rsp_start_rejected,
   // control registers
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   `include "assert_macros.svh"

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;

   ipdt_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ipdt_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (req_take),
      .item_op      (req_op),
      .item_command (req_command[CODE_BITS-1:0]),
      .cfg          (cfg),
      .result       (result)
   );

   // Output register frees up when empty or drained this cycle
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign req_take     = req_valid && !req_stall;
   assign rsp_valid_in = req_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_level     = rsp_ff.line_level;
   assign rsp_mark_active    = rsp_ff.mark_active;
   assign rsp_busy_res       = rsp_ff.busy_res;
   assign rsp_frame_done     = rsp_ff.frame_done;
   assign rsp_start_rejected = rsp_ff.start_rejected;

   `ASSERT_IMPLY(a_done_not_busy, clock, reset,
      rsp_valid_ff && rsp_ff.frame_done, !rsp_ff.busy_res)
   `ASSERT_IMPLY(a_reject_while_busy, clock, reset,
      rsp_valid_ff && rsp_ff.start_rejected, rsp_ff.busy_res)
   `ASSERT_IMPLY(a_level_needs_mark, clock, reset,
      rsp_valid_ff && rsp_ff.line_level, rsp_ff.mark_active)

endmodule

`default_nettype wire

@@ verif/infrared_pulse_distance_transmitter_tb.sv @@
// ----------------------------------------------------------------------------
// infrared_pulse_distance_transmitter_tb
// Self-checking testbench for the pulse-distance infrared transmitter.
// A clocked driver feeds tick and start transfers from a request queue.
// A clocked monitor predicts the status of every accepted transfer with a
// frame/carrier model kept inside the bench, and checks each response field.
// Runs cover reset timings, short and zero-length timings, a long lead mark
// with a full 8-bit carrier period, and random frames with noise.
// ----------------------------------------------------------------------------
`default_nettype none

module infrared_pulse_distance_transmitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ipdt_pkg::*;

   // Frame sequencing phases of the bench's transmitter model
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_LEAD_MARK  = 3'd1;
   localparam logic [2:0] PH_LEAD_SPACE = 3'd2;
   localparam logic [2:0] PH_BIT_MARK   = 3'd3;
   localparam logic [2:0] PH_BIT_SPACE  = 3'd4;
   localparam logic [2:0] PH_STOP_MARK  = 3'd5;
   localparam logic [2:0] PH_STOP_SPACE = 3'd6;

   typedef struct packed {
      logic        op;
      logic [31:0] command;
   } ir_request_type;

   localparam logic [31:0] CODE_MASK   = 32'hFFFF_FFFF >> (32 - CODE_BITS);
   localparam int          RANDOM_GOAL = 300;
   localparam int          PHASE_ITEMS = 150;

   // DUT connections
   logic                   clock;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic                   req_op             = OP_TICK;
   logic [31:0]            req_command        = '0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic                   rsp_line_level;
   logic                   rsp_mark_active;
   logic                   rsp_busy_res;
   logic                   rsp_frame_done;
   logic                   rsp_start_rejected;
   logic                   csr_write_enable   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index          = CSR_CARRIER_PERIOD;
   logic [CSR_DATA_W-1:0]  csr_write_data     = '0;

   // Bench state
   ir_request_type request_q[$];
   result_type     line_status_q[$];
   ir_request_type next_req;
   bit             req_taken    = 1'b0;
   bit             no_idle      = 1'b0;
   int             error_count  = 0;
   int             items_queued = 0;

   // Transmitter model state and register copy
   cfg_type      regs;
   logic [2:0]   frame_phase;
   logic [15:0]  phase_ticks;
   logic [7:0]   carrier_cnt;
   logic [5:0]   bits_left;
   logic [31:0]  code_word;

   infrared_pulse_distance_transmitter i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_command        (req_command),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_level     (rsp_line_level),
      .rsp_mark_active    (rsp_mark_active),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_start_rejected (rsp_start_rejected),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Transmitter model
   // ---------------------------------------------------------------------------
   function automatic logic is_mark(logic [2:0] p);
      return p == PH_LEAD_MARK || p == PH_BIT_MARK || p == PH_STOP_MARK;
   endfunction

   function automatic logic [15:0] phase_len();
      case (frame_phase)
         PH_LEAD_MARK:  return regs.lead_mark_ticks;
         PH_LEAD_SPACE: return regs.lead_space_ticks;
         PH_BIT_MARK:   return regs.bit_mark_ticks;
         PH_BIT_SPACE:  return code_word[CODE_BITS-1] ? regs.one_space_ticks
                                                      : regs.zero_space_ticks;
         PH_STOP_MARK:  return regs.bit_mark_ticks;
         PH_STOP_SPACE: return regs.stop_space_ticks;
         default:       return 16'd1;
      endcase
   endfunction

   // Carrier counter restarts with every mark
   function automatic void enter_phase(logic [2:0] p);
      frame_phase = p;
      phase_ticks = '0;
      if (is_mark(p))
         carrier_cnt = '0;
   endfunction

   // One microsecond; returns 1 when the stop space just ended
   function automatic logic advance_tick();
      logic [15:0] len;
      if (frame_phase == PH_IDLE)
         return 1'b0;
      if (is_mark(frame_phase))
         carrier_cnt = (carrier_cnt >= regs.carrier_period) ? 8'd0 : carrier_cnt + 8'd1;
      len = phase_len();
      phase_ticks = phase_ticks + 16'd1;
      // a zero length behaves as one tick
      if (phase_ticks < len && phase_ticks != 16'd0)
         return 1'b0;
      case (frame_phase)
         PH_LEAD_MARK:  enter_phase(PH_LEAD_SPACE);
         PH_LEAD_SPACE: enter_phase(PH_BIT_MARK);
         PH_BIT_MARK:   enter_phase(PH_BIT_SPACE);
         PH_BIT_SPACE: begin
            code_word = (code_word << 1) & CODE_MASK;
            bits_left = bits_left - 6'd1;
            enter_phase(bits_left == 6'd0 ? PH_STOP_MARK : PH_BIT_MARK);
         end
         PH_STOP_MARK:  enter_phase(PH_STOP_SPACE);
         PH_STOP_SPACE: begin
            frame_phase = PH_IDLE;
            phase_ticks = '0;
            return 1'b1;
         end
         default: begin
            frame_phase = PH_IDLE;
            phase_ticks = '0;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic result_type transmit_step(logic op, logic [31:0] cmd);
      result_type r;
      logic       mark;
      r = '0;
      if (op == OP_START) begin
         if (frame_phase != PH_IDLE) begin
            r.start_rejected = 1'b1;
         end else begin
            code_word = cmd & CODE_MASK;
            bits_left = 6'(CODE_BITS);
            enter_phase(PH_LEAD_MARK);
         end
      end else begin
         r.frame_done = advance_tick();
      end
      mark          = is_mark(frame_phase);
      r.line_level  = mark && (carrier_cnt < regs.carrier_high);
      r.mark_active = mark;
      r.busy_res    = frame_phase != PH_IDLE;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: register writes, request transfers and response checks
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type got;
      result_type want;
      string      field_names[5];
      field_names = '{"line_level", "mark_active", "busy_res", "frame_done",
                      "start_rejected"};
      if (reset) begin
         regs.carrier_period   = 8'd25;
         regs.carrier_high     = 8'd12;
         regs.lead_mark_ticks  = 16'd9000;
         regs.lead_space_ticks = 16'd4500;
         regs.bit_mark_ticks   = 16'd560;
         regs.one_space_ticks  = 16'd1690;
         regs.zero_space_ticks = 16'd560;
         regs.stop_space_ticks = 16'd1690;
         frame_phase = PH_IDLE;
         phase_ticks = '0;
         carrier_cnt = '0;
         bits_left   = '0;
         code_word   = '0;
         req_taken   = 1'b0;
      end else begin
         // response transfer belongs to an earlier request, so check first
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_line_level, rsp_mark_active, rsp_busy_res, rsp_frame_done,
                   rsp_start_rejected};
            if (line_status_q.size() == 0) begin
               $error("response transfer with no request outstanding");
               error_count++;
            end else begin
               want = line_status_q.pop_front();
               for (int i = 0; i < 5; i++) begin
                  if (got[4-i] !== want[4-i]) begin
                     $error("%s mismatch: expected %0b actual %0b", field_names[i],
                            want[4-i], got[4-i]);
                     error_count++;
                  end
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken)
            line_status_q.push_back(transmit_step(req_op, req_command));
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CARRIER_PERIOD: regs.carrier_period   = csr_write_data[7:0];
               CSR_CARRIER_HIGH:   regs.carrier_high     = csr_write_data[7:0];
               CSR_LEAD_MARK:      regs.lead_mark_ticks  = csr_write_data;
               CSR_LEAD_SPACE:     regs.lead_space_ticks = csr_write_data;
               CSR_BIT_MARK:       regs.bit_mark_ticks   = csr_write_data;
               CSR_ONE_SPACE:      regs.one_space_ticks  = csr_write_data;
               CSR_ZERO_SPACE:     regs.zero_space_ticks = csr_write_data;
               CSR_STOP_SPACE:     regs.stop_space_ticks = csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Driver: request channel and response back-pressure
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (request_q.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
            next_req     = request_q.pop_front();
            req_valid   <= 1'b1;
            req_op      <= next_req.op;
            req_command <= next_req.command;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 8);
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic void push_item(logic op, logic [31:0] cmd);
      request_q.push_back('{op: op, command: cmd});
      items_queued++;
   endfunction

   function automatic int span(logic [15:0] n);
      return (n == 16'd0) ? 1 : int'(n);
   endfunction

   // Ticks from a start until frame_done, at the current register values
   function automatic int frame_ticks(logic [31:0] cmd);
      int n;
      n = span(regs.lead_mark_ticks) + span(regs.lead_space_ticks)
        + span(regs.bit_mark_ticks) + span(regs.stop_space_ticks);
      for (int i = 0; i < CODE_BITS; i++)
         n += span(regs.bit_mark_ticks) + (cmd[CODE_BITS-1-i] ? span(regs.one_space_ticks)
                                                              : span(regs.zero_space_ticks));
      return n;
   endfunction

   function automatic logic [15:0] rand_len();
      return ($urandom_range(7) == 0) ? 16'($urandom_range(6, 40)) : 16'($urandom_range(0, 5));
   endfunction

   // Start plus exactly enough ticks; busy starts sprinkled in at reject_pct
   function automatic void run_frame(logic [31:0] cmd, int reject_pct);
      int n;
      n = frame_ticks(cmd);
      push_item(OP_START, cmd);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < reject_pct)
            push_item(OP_START, $urandom);
         push_item(OP_TICK, $urandom);
      end
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_timings(logic [15:0] lead_mark, logic [15:0] lead_space,
                                logic [15:0] bit_mark, logic [15:0] one_space,
                                logic [15:0] zero_space, logic [15:0] stop_space);
      write_reg(CSR_LEAD_MARK,  lead_mark);
      write_reg(CSR_LEAD_SPACE, lead_space);
      write_reg(CSR_BIT_MARK,   bit_mark);
      write_reg(CSR_ONE_SPACE,  one_space);
      write_reg(CSR_ZERO_SPACE, zero_space);
      write_reg(CSR_STOP_SPACE, stop_space);
   endtask

   // Sender holds off until every response has drained
   task automatic wait_quiet();
      do @(posedge clock); while (request_q.size() != 0 || req_valid);
      do @(negedge clock); while (line_status_q.size() != 0);
      repeat (4) @(negedge clock);
      @(posedge clock);
   endtask

   // Tick out whatever frame a noise burst left running
   task automatic finish_frame();
      while (frame_phase != PH_IDLE) begin
         for (int i = 0; i < 64; i++)
            push_item(OP_TICK, $urandom);
         wait_quiet();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      int          random_items;
      int          phase_start;
      int          phase_num;
      logic [7:0]  period;
      logic [7:0]  high;
      random_items = 0;
      phase_num    = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timings: idle tick, start, busy start, part of the lead mark
      push_item(OP_TICK, 32'hFFFF_FFFF);
      push_item(OP_START, 32'h0000_0000);
      push_item(OP_START, 32'hFFFF_FFFF);
      for (int i = 0; i < 40; i++)
         push_item(OP_TICK, $urandom);
      wait_quiet();

      // short timings; the running frame is cut short and ticked out,
      // then all-ones and all-zeros back to back
      write_reg(CSR_CARRIER_PERIOD, 16'd3);
      write_reg(CSR_CARRIER_HIGH, 16'd2);
      write_timings(16'd2, 16'd1, 16'd1, 16'd3, 16'd2, 16'd1);
      finish_frame();
      push_item(OP_TICK, 32'h0);
      run_frame(32'hFFFF_FFFF, 0);
      run_frame(32'h0000_0000, 0);
      run_frame(32'h8000_0001, 20);
      push_item(OP_TICK, 32'h0);
      wait_quiet();

      // zero carrier period, zero carrier high, zero-length phases
      write_reg(CSR_CARRIER_PERIOD, 16'h0000);
      write_reg(CSR_CARRIER_HIGH, 16'h0000);
      write_timings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_frame($urandom, 10);
      wait_quiet();
      write_reg(CSR_CARRIER_HIGH, 16'h00FF);
      run_frame($urandom, 10);
      wait_quiet();

      // long lead mark across a full wrap of the widest carrier, no idling
      no_idle = 1'b1;
      write_reg(CSR_CARRIER_PERIOD, 16'hA5FF);
      write_reg(CSR_CARRIER_HIGH, 16'hFF80);
      write_timings(16'd300, 16'd1, 16'd1, 16'd2, 16'd1, 16'd1);
      run_frame($urandom, 2);
      wait_quiet();
      no_idle = 1'b0;

      // random register settings, mostly well-formed frames
      while (random_items < RANDOM_GOAL) begin
         case ($urandom_range(3))
            0:       period = 8'd0;
            1:       period = 8'd1;
            2:       period = 8'($urandom_range(2, 12));
            default: period = 8'($urandom_range(13, 255));
         endcase
         high = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(0, period + 1));
         write_reg(CSR_CARRIER_PERIOD, {8'($urandom), period});
         write_reg(CSR_CARRIER_HIGH, {8'($urandom), high});
         write_timings(rand_len(), rand_len(), rand_len(), rand_len(), rand_len(), rand_len());
         no_idle     = (phase_num == 3);
         phase_start = items_queued;
         while (items_queued - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0) begin
               // noise: random ticks and starts
               for (int i = $urandom_range(10, 30); i > 0; i--)
                  push_item(1'($urandom), $urandom);
               wait_quiet();
               finish_frame();
            end else begin
               run_frame($urandom, $urandom_range(0, 5));
            end
         end
         wait_quiet();
         finish_frame();
         random_items += items_queued - phase_start;
         phase_num++;
      end
      no_idle = 1'b0;

      wait_quiet();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("infrared_pulse_distance_transmitter_tb passed");
      else
         $display("infrared_pulse_distance_transmitter_tb failed");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("infrared_pulse_distance_transmitter_tb failed");
      $finish;
   end

endmodule

`default_nettype wire
